### rtl/stb_pkg.sv
// shared types and constants for the software timer bank
// no dependencies; imported by every module of the block
package stb_pkg;

   localparam int SLOTS       = 8;
   localparam int MAX_REPORTS = 8;
   localparam int SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W       = $clog2(MAX_REPORTS + 1);
   localparam int ID_W        = 5;
   localparam int CNT_MAX     = 32;

   typedef enum logic [2:0] {
      ACT_TICK    = 3'd0,
      ACT_START   = 3'd1,
      ACT_SWITCH  = 3'd2,
      ACT_RESTART = 3'd3,
      ACT_DELETE  = 3'd4,
      ACT_CHECK   = 3'd5,
      ACT_SERVICE = 3'd6
   } action_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_BAD  = 2'd1,
      ST_NONE = 2'd2
   } status_type;

   typedef struct packed {
      logic [CNT_MAX-1:0] remaining;
      logic [CNT_MAX-1:0] reload;
      logic               running;
      logic               expired;
      logic               handler;
   } entry_type;

   typedef struct packed {
      logic [2:0]         action;
      logic [7:0]         slot;
      logic [CNT_MAX-1:0] duration;
      logic               repeat_req;
      logic               has_handler;
      logic               enable;
   } req_type;

   typedef struct packed {
      logic [ID_W-1:0] slot_id;
      logic            expired;
      status_type      status;
      logic            last;
   } rsp_type;

endpackage

### rtl/stb_alu.sv
// shared slot update unit: next contents of one slot for the current action
// depends on stb_pkg
module stb_alu (
   input  logic [2:0]             action,
   input  stb_pkg::req_type       req,
   input  stb_pkg::entry_type     cur,
   output stb_pkg::entry_type     nxt
);
   import stb_pkg::*;

   logic [CNT_MAX-1:0] dec;

   always_comb begin
      dec = (cur.remaining != '0) ? cur.remaining - 1'b1 : cur.remaining;
      nxt = cur;
      unique case (action_type'(action))
         ACT_TICK: begin
            if (cur.running) begin
               nxt.remaining = dec;
               if (dec == '0) begin
                  nxt.remaining = cur.reload;
                  nxt.running   = (cur.reload != '0);
                  nxt.expired   = 1'b1;
               end
            end
         end
         ACT_START: begin
            nxt.remaining = req.duration;
            if (req.repeat_req) begin
               nxt.reload = req.duration;
            end
            nxt.handler = req.has_handler;
            nxt.running = 1'b1;
            nxt.expired = 1'b0;
         end
         ACT_SWITCH: begin
            nxt.running = req.enable;
         end
         ACT_RESTART: begin
            nxt.remaining = req.duration;
            nxt.running   = 1'b1;
            nxt.expired   = 1'b0;
         end
         ACT_DELETE: begin
            nxt = '0;
         end
         ACT_SERVICE: begin
            nxt.expired = 1'b0;
         end
         default: begin
            nxt = cur;
         end
      endcase
   end

endmodule

### rtl/stb_table.sv
// slot table: per-slot counts and flags with one indexed read/write port
// depends on stb_pkg
module stb_table (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [stb_pkg::SLOT_W-1:0] idx,
   input  logic                       we,
   input  stb_pkg::entry_type         wr_entry,
   output stb_pkg::entry_type         rd_entry,
   output logic [stb_pkg::SLOTS-1:0]  qual
);
   import stb_pkg::*;

   logic [CNT_MAX-1:0] rem_ff [SLOTS];
   logic [CNT_MAX-1:0] rem_in [SLOTS];
   logic [CNT_MAX-1:0] rld_ff [SLOTS];
   logic [CNT_MAX-1:0] rld_in [SLOTS];
   logic [SLOTS-1:0]   run_ff, run_in;
   logic [SLOTS-1:0]   exp_ff, exp_in;
   logic [SLOTS-1:0]   hnd_ff, hnd_in;

   always_comb begin
      rem_in = rem_ff;
      rld_in = rld_ff;
      run_in = run_ff;
      exp_in = exp_ff;
      hnd_in = hnd_ff;
      if (we) begin
         rem_in[idx] = wr_entry.remaining;
         rld_in[idx] = wr_entry.reload;
         run_in[idx] = wr_entry.running;
         exp_in[idx] = wr_entry.expired;
         hnd_in[idx] = wr_entry.handler;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            rem_ff[i] <= '0;
            rld_ff[i] <= '0;
         end
         run_ff <= '0;
         exp_ff <= '0;
         hnd_ff <= '0;
      end else begin
         rem_ff <= rem_in;
         rld_ff <= rld_in;
         run_ff <= run_in;
         exp_ff <= exp_in;
         hnd_ff <= hnd_in;
      end
   end

   assign rd_entry.remaining = rem_ff[idx];
   assign rd_entry.reload    = rld_ff[idx];
   assign rd_entry.running   = run_ff[idx];
   assign rd_entry.expired   = exp_ff[idx];
   assign rd_entry.handler   = hnd_ff[idx];
   assign qual               = exp_ff & hnd_ff;

endmodule

### rtl/stb_ctrl.sv
// sequencer: accepts a request, walks slots for tick and service, issues result beats
// depends on stb_pkg
module stb_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_accept,
   input  stb_pkg::req_type           req,
   output logic                       busy,
   output logic [stb_pkg::SLOT_W-1:0] idx,
   output logic                       we,
   output logic [2:0]                 alu_action,
   output stb_pkg::req_type           req_held,
   input  stb_pkg::entry_type         rd_entry,
   input  logic [stb_pkg::SLOTS-1:0]  qual,
   input  logic                       out_free,
   output logic                       out_push,
   output stb_pkg::rsp_type           out_beat
);
   import stb_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_TICK,
      S_SERV,
      S_APPLY,
      S_RESP
   } state_type;

   state_type         state_ff, state_in;
   req_type           req_ff, req_in;
   logic [SLOT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   rsp_type           resp_ff, resp_in;
   logic [SLOTS-1:0]  above;
   logic              more;
   logic              at_end;
   logic              is_last;
   logic              bad;

   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         above[i] = (i > int'(idx_ff));
      end
   end

   assign more    = |(qual & above);
   assign at_end  = (idx_ff == SLOT_W'(SLOTS - 1));
   assign is_last = (cnt_ff == CNT_W'(MAX_REPORTS - 1)) || !more;
   assign bad     = (req.slot >= 8'(SLOTS));

   always_comb begin
      state_in = state_ff;
      req_in   = req_ff;
      idx_in   = idx_ff;
      cnt_in   = cnt_ff;
      resp_in  = resp_ff;
      we       = 1'b0;
      out_push = 1'b0;
      out_beat = resp_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               req_in = req;
               cnt_in = '0;
               idx_in = '0;
               unique case (action_type'(req.action))
                  ACT_TICK: begin
                     state_in = S_TICK;
                  end
                  ACT_SERVICE: begin
                     if (qual == '0) begin
                        resp_in  = '{slot_id: '0, expired: 1'b0, status: ST_NONE, last: 1'b1};
                        state_in = S_RESP;
                     end else begin
                        state_in = S_SERV;
                     end
                  end
                  ACT_START, ACT_SWITCH, ACT_RESTART, ACT_DELETE, ACT_CHECK: begin
                     if (bad) begin
                        resp_in  = '{slot_id: req.slot[ID_W-1:0], expired: 1'b0,
                                     status: ST_BAD, last: 1'b1};
                        state_in = S_RESP;
                     end else begin
                        idx_in   = req.slot[SLOT_W-1:0];
                        state_in = S_APPLY;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_TICK: begin
            we = 1'b1;
            if (at_end) begin
               state_in = S_IDLE;
            end else begin
               idx_in = SLOT_W'(idx_ff + 1'b1);
            end
         end
         S_SERV: begin
            out_beat = '{slot_id: ID_W'(idx_ff), expired: 1'b1, status: ST_OK, last: is_last};
            if (qual[idx_ff] && (cnt_ff < CNT_W'(MAX_REPORTS))) begin
               if (out_free) begin
                  out_push = 1'b1;
                  we       = 1'b1;
                  cnt_in   = CNT_W'(cnt_ff + 1'b1);
                  if (is_last || at_end) begin
                     state_in = S_IDLE;
                  end else begin
                     idx_in = SLOT_W'(idx_ff + 1'b1);
                  end
               end
            end else if (at_end) begin
               state_in = S_IDLE;
            end else begin
               idx_in = SLOT_W'(idx_ff + 1'b1);
            end
         end
         S_APPLY: begin
            we       = (action_type'(req_ff.action) != ACT_CHECK);
            resp_in  = '{slot_id: ID_W'(idx_ff),
                         expired: (action_type'(req_ff.action) == ACT_CHECK) && rd_entry.expired,
                         status: ST_OK, last: 1'b1};
            state_in = S_RESP;
         end
         S_RESP: begin
            if (out_free) begin
               out_push = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff   <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         cnt_ff   <= cnt_in;
      end
      req_ff  <= req_in;
      resp_ff <= resp_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign idx        = idx_ff;
   assign alu_action = req_ff.action;
   assign req_held   = req_ff;

   a_push_free: assert property (@(posedge clock) disable iff (reset)
      out_push |-> out_free)
      else $error("result beat issued into a full output register");

   a_write_busy: assert property (@(posedge clock) disable iff (reset)
      we |-> (state_ff != S_IDLE))
      else $error("slot table written while idle");

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (out_push && out_beat.last) |=> (state_ff == S_IDLE))
      else $error("sequencer still busy after final beat");

   a_cnt_cap: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_REPORTS))
      else $error("service report count beyond limit");

endmodule

### rtl/software_timer_bank_unit.sv
// software timer bank top level: sequencer, slot table, update unit, output register
// tick walks every slot per request; service walks slots, holding on output stalls;
// other actions access one slot, then give a beat (only the beat for bad slot, no service)
// result beats sit in an output register, so the next request is taken while one waits
// synchronous active-high reset clears every slot and the sequencer; no clearing pass
// depends on stb_pkg, stb_alu, stb_table, stb_ctrl
module software_timer_bank_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [2:0]                   req_action,
   input  logic [7:0]                   req_slot,
   input  logic [stb_pkg::CNT_MAX-1:0]  req_duration,
   input  logic                         req_repeat_req,
   input  logic                         req_has_handler,
   input  logic                         req_enable,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [stb_pkg::ID_W-1:0]     rsp_slot_id,
   output logic                         rsp_expired,
   output logic [1:0]                   rsp_status,
   output logic                         rsp_last
);
   import stb_pkg::*;

   req_type           req;
   req_type           req_held;
   logic              busy;
   logic [SLOT_W-1:0] idx;
   logic              we;
   logic [2:0]        alu_action;
   entry_type         rd_entry;
   entry_type         wr_entry;
   logic [SLOTS-1:0]  qual;
   logic              out_free;
   logic              out_push;
   rsp_type           out_beat;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_beat_ff, rsp_beat_in;

   assign req = '{action: req_action, slot: req_slot, duration: req_duration,
                  repeat_req: req_repeat_req, has_handler: req_has_handler,
                  enable: req_enable};

   assign req_stall = busy;

   stb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_valid && !busy),
      .req        (req),
      .busy       (busy),
      .idx        (idx),
      .we         (we),
      .alu_action (alu_action),
      .req_held   (req_held),
      .rd_entry   (rd_entry),
      .qual       (qual),
      .out_free   (out_free),
      .out_push   (out_push),
      .out_beat   (out_beat)
   );

   stb_table u_table (
      .clock    (clock),
      .reset    (reset),
      .idx      (idx),
      .we       (we),
      .wr_entry (wr_entry),
      .rd_entry (rd_entry),
      .qual     (qual)
   );

   stb_alu u_alu (
      .action (alu_action),
      .req    (req_held),
      .cur    (rd_entry),
      .nxt    (wr_entry)
   );

   // output beat register
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_beat_in  = rsp_beat_ff;
      if (out_push) begin
         rsp_valid_in = 1'b1;
         rsp_beat_in  = out_beat;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_beat_ff <= rsp_beat_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_slot_id = rsp_beat_ff.slot_id;
   assign rsp_expired = rsp_beat_ff.expired;
   assign rsp_status  = rsp_beat_ff.status;
   assign rsp_last    = rsp_beat_ff.last;

endmodule
